// File: src/vtb_pkg.sv
package vtb_pkg;
  localparam int NUM_STATES = 64;
  localparam int STATE_W = 6;
  localparam int METRIC_W = 28;
  localparam int TB_DEPTH_DEF = 33;
  localparam logic [METRIC_W-1:0] NORM_LIMIT = 28'd100000000;
  localparam logic [METRIC_W-1:0] INIT_METRIC = 28'd500;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    BK_CLR,
    BK_IDLE,
    BK_ACS,
    BK_NORM,
    BK_TRACE,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic r0;
    logic r1;
  } sym_t;

  // expected code bit pair {first, second} leaving state prev on input b
  function automatic logic [1:0] expect_bits(input logic [STATE_W-1:0] prev, input logic b);
    logic first;
    logic second;
    first = b ^ prev[1] ^ prev[2] ^ prev[4] ^ prev[5];
    second = b ^ prev[0] ^ prev[1] ^ prev[2] ^ prev[5];
    return {first, second};
  endfunction

  function automatic logic [1:0] hamming(input logic [1:0] e, input sym_t s);
    return {1'b0, e[1] ^ s.r0} + {1'b0, e[0] ^ s.r1};
  endfunction
endpackage

// File: src/vtb_stream_if.sv
interface vtb_stream_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/viterbi_decoder_k7_hard_top.sv
// Each request passes the one-state-per-cycle ACS sweep, the metric write-back sweep,
// the one-step-per-cycle traceback and an output stage. The back end takes a new
// request only after it has placed the last result in its output register.
// A two-entry request queue takes input while the back end works.
// Reset (rst_n low, synchronous) sets mode to zero; a pass over all states after reset
// loads metrics with 0/500 and clears survivors before the first request starts.
module viterbi_decoder_k7_hard_top
  import vtb_pkg::*;
#(
  parameter int TRACEBACK_DEPTH = TB_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vtb_stream_if.sink in_ch,
  vtb_stream_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic mode_r;
  logic q_valid, q_take;
  sym_t q_sym, in_sym;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, mode_r};
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
      mode_r <= cfg_pwdata[0];
  end

  assign in_sym = '{r0: in_ch.data[0], r1: in_ch.data[1]};

  vtb_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_sym,
    .q_valid, .q_take, .q_sym
  );

  vtb_back #(.TRACEBACK_DEPTH(TRACEBACK_DEPTH)) u_back (
    .clk, .rst_n, .fixed_start_mode(mode_r),
    .q_valid, .q_take, .q_sym,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bit(out_ch.data[0])
  );
endmodule

// File: src/vtb_front.sv
// Input request queue: accepts symbol pairs, buffers them for the back end.
module vtb_front
  import vtb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sym_t in_sym,
  output logic q_valid,
  input  logic q_take,
  output sym_t q_sym
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  sym_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_sym = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_sym;
  end
endmodule

// File: src/vtb_back.sv
// ACS over one state per cycle, metric normalization sweep, traceback one step per cycle.
// Storage uses synchronous reads; read addresses come from the next-state values.
module vtb_back
  import vtb_pkg::*;
#(
  parameter int TRACEBACK_DEPTH = TB_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fixed_start_mode,
  input  logic q_valid,
  output logic q_take,
  input  sym_t q_sym,
  output logic out_valid,
  input  logic out_ready,
  output logic out_bit
);
  localparam int TW = $clog2(TRACEBACK_DEPTH);

  logic [METRIC_W-1:0] pm_r [NUM_STATES];
  logic [METRIC_W-1:0] nm_r [NUM_STATES];
  logic [TRACEBACK_DEPTH-1:0] sv_r [NUM_STATES];
  logic [METRIC_W-1:0] pmu_r, pmd_r, nmq_r;
  logic [TRACEBACK_DEPTH-1:0] svq_r;

  bk_state_t st_r, st_nxt;
  logic [STATE_W:0] idx_r, idx_nxt;
  logic [TW-1:0] step_r, step_nxt;
  logic [STATE_W-1:0] best_r, best_nxt, s_r, s_nxt;
  logic [METRIC_W-1:0] bestm_r, bestm_nxt;
  logic norm_r, norm_nxt;
  sym_t sym_r, sym_nxt;
  logic ov_r, ov_nxt, ob_r, ob_nxt;

  logic [STATE_W-1:0] ns, pu, pd, ra, sv_ra;
  logic [METRIC_W-1:0] up, dn, nmv, pm_wd;
  logic dec;
  logic acs_we, norm_we, clr_we, pm_we;

  always_comb begin
    ns = idx_r[STATE_W-1:0];
    pu = {1'b0, ns[STATE_W-1:1]};
    pd = {1'b1, ns[STATE_W-1:1]};
    up = pmu_r + METRIC_W'(hamming(expect_bits(pu, ns[0]), sym_r));
    dn = pmd_r + METRIC_W'(hamming(expect_bits(pd, ns[0]), sym_r));
    dec = (up > dn);
    nmv = dec ? dn : up;
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    best_nxt = best_r;
    bestm_nxt = bestm_r;
    norm_nxt = norm_r;
    sym_nxt = sym_r;
    s_nxt = s_r;
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    q_take = 1'b0;
    acs_we = 1'b0;
    norm_we = 1'b0;
    clr_we = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      // load start metrics and clear survivors, one state per cycle
      BK_CLR: begin
        clr_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (STATE_W+1)'(NUM_STATES-1)) begin
          idx_nxt = '0;
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          sym_nxt = q_sym;
          idx_nxt = '0;
          norm_nxt = 1'b0;
          best_nxt = '0;
          st_nxt = BK_ACS;
        end
      end
      BK_ACS: begin
        acs_we = 1'b1;
        if (nmv > NORM_LIMIT) norm_nxt = 1'b1;
        if (idx_r == '0 || nmv < bestm_r) begin
          bestm_nxt = nmv;
          best_nxt = ns;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (STATE_W+1)'(NUM_STATES-1)) begin
          idx_nxt = '0;
          st_nxt = BK_NORM;
        end
      end
      BK_NORM: begin
        norm_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (STATE_W+1)'(NUM_STATES-1)) begin
          idx_nxt = '0;
          s_nxt = fixed_start_mode ? '0 : best_r;
          step_nxt = '0;
          st_nxt = (TRACEBACK_DEPTH > 1) ? BK_TRACE : BK_OUT;
        end
      end
      BK_TRACE: begin
        s_nxt = {svq_r[step_r], s_r[STATE_W-1:1]};
        step_nxt = step_r + 1'b1;
        if (step_r == TW'(TRACEBACK_DEPTH-2)) st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          ob_nxt = s_r[0];
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ra = idx_nxt[STATE_W-1:0];
    sv_ra = (st_nxt == BK_TRACE) ? s_nxt : ra;
    pm_we = clr_we || norm_we;
    if (clr_we) pm_wd = (ns == '0) ? '0 : INIT_METRIC;
    else if (!norm_r) pm_wd = nmq_r;
    else if (nmq_r > NORM_LIMIT) pm_wd = nmq_r - NORM_LIMIT;
    else pm_wd = '0;
  end

  assign out_valid = ov_r;
  assign out_bit = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLR;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      idx_r <= idx_nxt;
    end
    step_r <= step_nxt;
    best_r <= best_nxt;
    bestm_r <= bestm_nxt;
    norm_r <= norm_nxt;
    sym_r <= sym_nxt;
    s_r <= s_nxt;
    ob_r <= ob_nxt;
  end

  // metric and survivor storage
  always_ff @(posedge clk) begin
    pmu_r <= pm_r[{1'b0, ra[STATE_W-1:1]}];
    pmd_r <= pm_r[{1'b1, ra[STATE_W-1:1]}];
    nmq_r <= nm_r[ra];
    svq_r <= sv_r[sv_ra];
    if (pm_we) pm_r[ns] <= pm_wd;
    if (acs_we) nm_r[ns] <= nmv;
    if (acs_we) sv_r[ns] <= {svq_r[TRACEBACK_DEPTH-2:0], dec};
    else if (clr_we) sv_r[ns] <= '0;
  end
endmodule

// File: src/vtb_checker.sv
module vtb_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit,
  input logic in_valid,
  input logic in_ready,
  input logic cfg_pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bit)) else $error("out dropped");
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in request withdrawn");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_bit)) else $error("out bit unknown");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind viterbi_decoder_k7_hard_top vtb_checker u_chk (
  .clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bit(out_ch.data[0]),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .cfg_pready
);

// File: tb/viterbi_decoder_k7_hard_top_tb.sv
module viterbi_decoder_k7_hard_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vtb_pkg::*;

  localparam logic [0:0] REG_FIXED_START = 1'b0;
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic r0;
    logic r1;
    logic mode;
    bit   known;
    logic bit_exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [0:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  vtb_stream_if #(.W(2)) in_if ();
  vtb_stream_if #(.W(1)) out_if ();

  viterbi_decoder_k7_hard_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // decoder state mirror
  logic [METRIC_W-1:0] metric_mirror [NUM_STATES];
  logic [TB_DEPTH_DEF-1:0] surv_mirror [NUM_STATES];
  logic start_mode;

  logic expected_bits[$];
  int errors;
  int n_sent;
  int n_checked;
  int n_mode1;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;
  logic [STATE_W-1:0] enc_state;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("viterbi_decoder_k7_hard_top test failed");
    $finish;
  end

  function automatic logic [1:0] code_pair(input logic [STATE_W-1:0] st, input logic b);
    code_pair[1] = b ^ st[1] ^ st[2] ^ st[4] ^ st[5];
    code_pair[0] = b ^ st[0] ^ st[1] ^ st[2] ^ st[5];
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < NUM_STATES; i++) begin
      metric_mirror[i] = (i == 0) ? '0 : 28'd500;
      surv_mirror[i] = '0;
    end
    start_mode = 1'b0;
  endfunction

  // one ACS step with best-state pick and normalization, then traceback; returns the decoded bit
  function automatic logic decode_step(input logic r0, input logic r1);
    logic [31:0] nm [NUM_STATES];
    logic [31:0] up;
    logic [31:0] dn;
    logic [1:0] cu;
    logic [1:0] cd;
    logic [STATE_W-1:0] pu;
    logic [STATE_W-1:0] pd;
    logic [STATE_W-1:0] s;
    logic [31:0] bestm;
    logic dec;
    bit norm;
    norm = 0;
    for (int i = 0; i < NUM_STATES; i++) begin
      pu = STATE_W'(i >> 1);
      pd = pu + 6'd32;
      cu = code_pair(pu, i[0]);
      cd = code_pair(pd, i[0]);
      up = metric_mirror[pu] + (cu[1] ^ r0) + (cu[0] ^ r1);
      dn = metric_mirror[pd] + (cd[1] ^ r0) + (cd[0] ^ r1);
      dec = (up > dn);
      nm[i] = dec ? dn : up;
      if (nm[i] > 32'd100000000) norm = 1;
      surv_mirror[i] = {surv_mirror[i][TB_DEPTH_DEF-2:0], dec};
    end
    s = '0;
    if (!start_mode) begin
      bestm = nm[0];
      for (int i = 1; i < NUM_STATES; i++) begin
        if (nm[i] < bestm) begin
          bestm = nm[i];
          s = STATE_W'(i);
        end
      end
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      if (norm) nm[i] = (nm[i] > 32'd100000000) ? nm[i] - 32'd100000000 : 32'd0;
      metric_mirror[i] = nm[i][METRIC_W-1:0];
    end
    for (int k = 0; k < TB_DEPTH_DEF - 1; k++)
      s = {surv_mirror[s][k], s[STATE_W-1:1]};
    return s[0];
  endfunction

  task automatic send_pair(input logic r0, input logic r1, input bit known, input logic bit_exp);
    logic pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {r1, r0};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = decode_step(r0, r1);
    if (known && pred !== bit_exp)
      $display("%0t note: mirror gives %0b where %0b was typed", $time, pred, bit_exp);
    expected_bits.push_back(known ? bit_exp : pred);
    n_sent++;
    if (start_mode) n_mode1++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_mode(input logic v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_FIXED_START;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    start_mode = v;
  endtask

  // mostly a clean encoded stream with sparse bit errors, some raw noise
  task automatic send_random(input int count);
    logic b;
    logic [1:0] cp;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) begin
        b = 1'($urandom_range(1));
        cp = code_pair(enc_state, b);
        enc_state = {enc_state[STATE_W-2:0], b};
        if ($urandom_range(99) < 4) cp[1] = ~cp[1];
        if ($urandom_range(99) < 4) cp[0] = ~cp[0];
      end else begin
        cp = 2'($urandom_range(3));
      end
      send_pair(cp[1], cp[0], 0, 1'b0);
    end
  endtask

  // result side
  always @(posedge clk) begin
    logic want;
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_bits.size() == 0) begin
        $display("%0t unexpected result: actual %0b", $time, out_if.data);
        errors++;
      end else begin
        want = expected_bits.pop_front();
        if (out_if.data !== want) begin
          $display("%0t decoded_bit mismatch: expected %0b actual %0b",
                   $time, want, out_if.data);
          errors++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    logic cur_mode;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_mode1 = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 0;
    enc_state = '0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    clear_mirror();

    // r0, r1, mode, typed, value
    dir_rows = '{
      '{1'b0, 1'b0, 1'b0, 1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1, 1'b0}, '{1'b1, 1'b1, 1'b0, 0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 0, 1'b0}, '{1'b0, 1'b1, 1'b0, 0, 1'b0},
      '{1'b1, 1'b1, 1'b0, 0, 1'b0}, '{1'b1, 1'b1, 1'b0, 0, 1'b0},
      '{1'b0, 1'b1, 1'b0, 0, 1'b0}, '{1'b1, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0, 1'b0, 1'b0, 0, 1'b0}, '{1'b1, 1'b1, 1'b1, 0, 1'b0},
      '{1'b1, 1'b0, 1'b1, 0, 1'b0}, '{1'b0, 1'b1, 1'b1, 0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 0, 1'b0}, '{1'b1, 1'b1, 1'b1, 0, 1'b0},
      '{1'b1, 1'b0, 1'b1, 0, 1'b0}, '{1'b0, 1'b0, 1'b1, 0, 1'b0},
      '{1'b1, 1'b1, 1'b0, 0, 1'b0}, '{1'b0, 1'b1, 1'b0, 0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_mode = 1'b0;
    write_start_mode(1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode !== cur_mode) begin
        drain_results();
        write_start_mode(dir_rows[i].mode);
        cur_mode = dir_rows[i].mode;
      end
      send_pair(dir_rows[i].r0, dir_rows[i].r1, dir_rows[i].known, dir_rows[i].bit_exp);
    end

    // phase 1: sparse sender gaps, frequent receiver stalls, best-state start
    drain_results();
    write_start_mode(1'b0);
    tx_idle_pct = 6;
    rx_idle_pct = 57;
    send_random(250);
    drain_results();
    send_random(200);

    // phase 2: roles swapped, fixed start from state zero
    drain_results();
    write_start_mode(1'b1);
    tx_idle_pct = 57;
    rx_idle_pct = 6;
    send_random(450);

    // phase 3: no gaps; a long receiver hold first so the input backs up
    drain_results();
    write_start_mode(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 3000;
    send_random(430);

    drain_results();
    $display("covered %0d bit pairs (%0d from state zero), %0d decoded bits checked",
             n_sent, n_mode1, n_checked);
    $display("stalls, long back-pressure and both traceback start modes exercised");
    if (errors == 0) begin
      $display("viterbi_decoder_k7_hard_top test passed");
    end else begin
      $display("viterbi_decoder_k7_hard_top test failed");
    end
    $finish;
  end
endmodule
